// ===== design/sewr_pkg.sv =====
// Shared constants, types and the gain quantizer for the sensor exposure/gain writer.
// Used by sewr_divider and sensor_exposure_gain_register_writer; depends on nothing.
package sewr_pkg;

	localparam int EXP_W   = 24;
	localparam int GAIN_W  = 10;
	localparam int LINES_W = 16;
	localparam int ADDR_W  = 16;
	localparam int BYTE_W  = 8;

	// Number of quotient bits produced by the serial divider, one per cycle.
	localparam int DIV_STEPS = EXP_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [ADDR_W-1:0] ADDR_GAIN     = 16'h0205;
	localparam logic [ADDR_W-1:0] ADDR_LINES_HI = 16'h0202;
	localparam logic [ADDR_W-1:0] ADDR_LINES_LO = 16'h0203;
	localparam logic [ADDR_W-1:0] ADDR_HOLD     = 16'h0104;

	localparam logic [1:0] PHASE_LAST = 2'd2;

	localparam logic [BYTE_W-1:0] GAIN_CODE_MAX = 8'hF0;
	localparam logic [BYTE_W-1:0] SHADOW_RESET  = 8'hFF;
	localparam logic [EXP_W-1:0]  PREV_EXP_RESET  = 24'd3240;
	localparam logic [GAIN_W-1:0] PREV_GAIN_RESET = 10'd16;
	localparam logic [LINES_W-1:0] LINE_TIME_RESET = 16'd1;

	typedef enum logic [1:0] {
		OP_BOTH     = 2'd0,
		OP_EXPOSURE = 2'd1,
		OP_GAIN     = 2'd2,
		OP_UNUSED   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		WR_GAIN     = 3'd0,
		WR_LINES_HI = 3'd1,
		WR_LINES_LO = 3'd2,
		WR_HOLD_SET = 3'd3,
		WR_HOLD_CLR = 3'd4
	} write_step_t;

	// Round the Q6.4 gain down to the sensor's gain ladder (min 1.0); return its code.
	function automatic logic [BYTE_W-1:0] gain_code(input logic [GAIN_W-1:0] g);
		logic [GAIN_W-1:0] q;
		logic [BYTE_W-1:0] code;
		q = g;
		if (g < 10'd16) begin
			q = 10'd16;
		end else if (g < 10'd32) begin
			q = g;
		end else if (g < 10'd64) begin
			q = {g[GAIN_W-1:1], 1'b0};
		end else if (g < 10'd128) begin
			q = {g[GAIN_W-1:2], 2'b00};
		end else if (g < 10'd256) begin
			q = {g[GAIN_W-1:3], 3'b000};
		end
		if (g >= 10'd256) begin
			code = GAIN_CODE_MAX;
		end else begin
			code = q[BYTE_W-1:0] - 8'd16;
		end
		return code;
	endfunction

endpackage

// ===== design/sewr_divider.sv =====
// Bit-serial restoring divider: 24-bit exposure by 16-bit line time, one quotient bit a cycle.
// Depends on sewr_pkg for the widths and the step count.
module sewr_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [23:0] quotient
);
	import sewr_pkg::*;

	logic [EXP_W-1:0]     dvd_q;
	logic [LINES_W-1:0]   rem_q;
	logic [LINES_W-1:0]   dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [LINES_W:0]   rem_shift;
	logic [LINES_W+1:0] diff;
	logic               qbit;

	// The dividend register shifts out the numerator at the top and takes the
	// quotient bits in at the bottom, so it holds the quotient at the end.
	always_comb begin
		rem_shift = {rem_q, dvd_q[EXP_W-1]};
		diff      = {1'b0, rem_shift} - {2'b00, dsr_q};
		qbit      = ~diff[LINES_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			// A zero line time behaves as a line time of one.
			dsr_q <= (divisor == '0) ? LINES_W'(1) : divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[EXP_W-2:0], qbit};
			rem_q <= qbit ? diff[LINES_W-1:0] : rem_shift[LINES_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== design/sensor_exposure_gain_register_writer.sv =====
// Sensor exposure/gain register writer: turns auto-exposure requests into register writes.
// Depends on sewr_pkg and sewr_divider.
//
// Each request is accepted while the block is idle, and the input stalls until that
// request has been handled. Requests that write nothing and need no line count (skipped
// combined calls, an unchanged gain code, opcode 3) are done in the cycle they are
// accepted. A gain-only request that writes loads its three writes one after another,
// and the next request can follow once the last of them is loaded. Requests that need a
// line count run the bit-serial divider, and their first write is loaded once it is
// done: a combined request then loads five writes, an exposure-only request four, or
// none when its line count is unchanged. A stalled output holds back a waiting write.
// The line_time register may be written at any time the block is idle and its ready
// is always high.
module sensor_exposure_gain_register_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [23:0] exposure_time,
	input  logic [9:0]  gain_q4,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] reg_address,
	output logic [7:0]  reg_value,
	output logic        last_write
);
	import sewr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DIVIDE = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t              state_q;
	write_step_t         step_q;
	write_step_t         step_next;
	logic [LINES_W-1:0]  line_time_q;
	logic [EXP_W-1:0]    prev_exp_q;
	logic [GAIN_W-1:0]   prev_gain_q;
	logic [BYTE_W-1:0]   hi_shadow_q;
	logic [BYTE_W-1:0]   lo_shadow_q;
	logic [BYTE_W-1:0]   code_shadow_q;
	logic [1:0]          phase_q;
	logic [1:0]          op_q;
	logic [EXP_W-1:0]    exp_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [BYTE_W-1:0]   code_q;
	logic [LINES_W-1:0]  lines_q;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [BYTE_W-1:0]   value_q;
	logic                last_q;

	logic                accept;
	logic                div_start;
	logic                div_done;
	logic [EXP_W-1:0]    quotient;
	logic [LINES_W-1:0]  lines_sat;
	logic [BYTE_W-1:0]   in_code;
	logic                both_acts;
	logic                load_out;
	logic [ADDR_W-1:0]   wr_addr;
	logic [BYTE_W-1:0]   wr_value;
	logic                wr_last;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign in_code   = gain_code(gain_q4);

	// A combined request acts only on the third call, and then only if something changed.
	assign both_acts = (phase_q == PHASE_LAST) &&
	                   !(exposure_time == prev_exp_q && gain_q4 == prev_gain_q);
	assign div_start = accept && ((opcode == OP_BOTH && both_acts) || opcode == OP_EXPOSURE);

	sewr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (exposure_time),
		.divisor  (line_time_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign lines_sat = (|quotient[EXP_W-1:LINES_W]) ? '1 : quotient[LINES_W-1:0];
	assign load_out  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		wr_addr   = ADDR_HOLD;
		wr_value  = '0;
		wr_last   = 1'b0;
		step_next = WR_HOLD_CLR;
		case (step_q)
			WR_GAIN: begin
				wr_addr   = ADDR_GAIN;
				wr_value  = code_q;
				step_next = (op_q == OP_GAIN) ? WR_HOLD_SET : WR_LINES_HI;
			end
			WR_LINES_HI: begin
				wr_addr   = ADDR_LINES_HI;
				wr_value  = lines_q[LINES_W-1:BYTE_W];
				step_next = WR_LINES_LO;
			end
			WR_LINES_LO: begin
				wr_addr   = ADDR_LINES_LO;
				wr_value  = lines_q[BYTE_W-1:0];
				step_next = WR_HOLD_SET;
			end
			WR_HOLD_SET: begin
				wr_addr   = ADDR_HOLD;
				wr_value  = 8'd1;
				step_next = WR_HOLD_CLR;
			end
			WR_HOLD_CLR: begin
				wr_addr   = ADDR_HOLD;
				wr_value  = 8'd0;
				wr_last   = 1'b1;
				step_next = WR_HOLD_CLR;
			end
			default: begin
				wr_addr   = ADDR_HOLD;
				wr_value  = 8'd0;
				wr_last   = 1'b1;
				step_next = WR_HOLD_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= WR_GAIN;
			line_time_q   <= LINE_TIME_RESET;
			prev_exp_q    <= PREV_EXP_RESET;
			prev_gain_q   <= PREV_GAIN_RESET;
			hi_shadow_q   <= SHADOW_RESET;
			lo_shadow_q   <= SHADOW_RESET;
			code_shadow_q <= SHADOW_RESET;
			phase_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				line_time_q <= cfg_data;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
				step_q      <= step_next;
				if (wr_last) begin
					state_q <= ST_IDLE;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_BOTH: begin
								phase_q <= (phase_q == PHASE_LAST) ? 2'd0 : phase_q + 2'd1;
								if (both_acts) begin
									state_q <= ST_DIVIDE;
								end
							end
							OP_EXPOSURE: begin
								state_q <= ST_DIVIDE;
							end
							OP_GAIN: begin
								if (in_code != code_shadow_q) begin
									code_shadow_q <= in_code;
									prev_gain_q   <= gain_q4;
									step_q        <= WR_GAIN;
									state_q       <= ST_EMIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIVIDE: begin
					if (div_done) begin
						if (op_q == OP_BOTH) begin
							hi_shadow_q   <= lines_sat[LINES_W-1:BYTE_W];
							lo_shadow_q   <= lines_sat[BYTE_W-1:0];
							code_shadow_q <= code_q;
							prev_exp_q    <= exp_q;
							prev_gain_q   <= gain_q;
							step_q        <= WR_GAIN;
							state_q       <= ST_EMIT;
						end else if (lines_sat == {hi_shadow_q, lo_shadow_q}) begin
							state_q <= ST_IDLE;
						end else begin
							hi_shadow_q <= lines_sat[LINES_W-1:BYTE_W];
							lo_shadow_q <= lines_sat[BYTE_W-1:0];
							prev_exp_q  <= exp_q;
							step_q      <= WR_LINES_HI;
							state_q     <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			exp_q  <= exposure_time;
			gain_q <= gain_q4;
			code_q <= in_code;
		end
		if (div_done) begin
			lines_q <= lines_sat;
		end
		if (load_out) begin
			addr_q  <= wr_addr;
			value_q <= wr_value;
			last_q  <= wr_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign reg_address = addr_q;
	assign reg_value   = value_q;
	assign last_write  = last_q;

endmodule
